// ===== rtl/kedg_pkg.sv =====
package kedg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int GAIN_W    = 17;
  localparam int REG_W     = 3;

  localparam longint unsigned ONE_U   = 64'd1 << FRAC_BITS;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // rounded constants
  localparam longint unsigned K062_U   = (64'd62 * ONE_U + 64'd50) / 64'd100;
  localparam longint unsigned K095_U   = (64'd95 * Q30_ONE + 64'd50) / 64'd100;
  localparam longint unsigned K038_U   = (64'd38 * Q30_ONE + 64'd50) / 64'd100;
  localparam longint unsigned K01_U    = (Q30_ONE + 64'd5) / 64'd10;
  localparam longint unsigned K01184_U = (64'd1184 * Q30_ONE + 64'd5000) / 64'd10000;
  localparam longint unsigned K04_U    = (64'd4 * Q30_ONE + 64'd5) / 64'd10;
  localparam longint unsigned K0225_U  =
    (64'd225 * (64'd1 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000;
  localparam longint unsigned T24_U    = (64'd24 * ONE_U + 64'd5) / 64'd10;

  localparam logic [29:0] K095   = 30'(K095_U);
  localparam logic [28:0] K038   = 29'(K038_U);
  localparam logic [26:0] K01    = 27'(K01_U);
  localparam logic [26:0] K01184 = 27'(K01184_U);
  localparam logic [28:0] K04    = 29'(K04_U);
  localparam logic [30:0] K0225  = 31'(K0225_U);
  localparam logic [15:0] K062   = 16'(K062_U);

  localparam logic signed [IN_W-1:0] V_NEG_ONE = -(IN_W'(ONE_U));
  localparam logic signed [IN_W-1:0] V_ZERO    = '0;
  localparam logic signed [IN_W-1:0] V_ONE     = IN_W'(ONE_U);
  localparam logic signed [IN_W-1:0] V_T24     = IN_W'(T24_U);

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(ONE_U);
  localparam logic [GAIN_W-1:0] GAIN_HALF = GAIN_W'(ONE_U >> 1);

  localparam int EXP_TERMS = 16;
  localparam int SQ_STEPS  = 29;
  localparam int RCP_STEPS = 13;

  // stage where each lane's gain (reciprocal, circular, exp) is merged into the common pipe
  localparam int RCP_INS  = 2 + RCP_STEPS;
  localparam int CIRC_INS = 5 + SQ_STEPS;
  localparam int EXP_INS  = 2 + 3 * EXP_TERMS;
  localparam int LAST     = EXP_INS;
  localparam int LATENCY  = LAST + 1;

  typedef enum logic [REG_W-1:0] {
    REG_BELOW = 3'd0,
    REG_LIN   = 3'd1,
    REG_EXP   = 3'd2,
    REG_CIRC  = 3'd3,
    REG_RCP   = 3'd4
  } region_t;

endpackage

// ===== rtl/knife_edge_diffraction_gain.sv =====
// Channel   | Ports                                   | Beat taken when
// ----------+-----------------------------------------+-------------------------
// input     | start, busy, in_diffraction_param[23:0] | start && !busy at clk
// result    | out_valid, out_field_gain[16:0],        | out_valid, one cycle,
//           | out_region[2:0]                         | receiver cannot stall
//
// One beat per cycle in, one per cycle out. Result timing is set by the exp
// piece, the longest lane: 16 Taylor terms, each a multiply stage, a
// reciprocal-multiply stage and a correction stage. Pieces run in parallel
// lanes into one pipe.
// rst_n is synchronous; it clears the valid pipe and holds busy high.
// busy is low otherwise: nothing in the block ever stalls.
module knife_edge_diffraction_gain (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [23:0]      in_diffraction_param,
  output logic                    out_valid,
  output logic [16:0]             out_field_gain,
  output logic [2:0]              out_region
);

  localparam int LAST = kedg_pkg::LAST;

  // ---------------------------------------------------------------- stage 0
  logic signed [23:0] v0_r;
  logic               vld_r [0:LAST];
  kedg_pkg::region_t  region_r [1:LAST];
  kedg_pkg::region_t  region_nxt;
  logic [16:0]        gain_r   [1:LAST];
  logic [16:0]        gain_nxt [1:LAST];

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    v0_r <= in_diffraction_param;
  end

  // valid bits ride alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int k = 1; k <= LAST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ------------------------------------------------------- region decision
  always_comb begin
    if (v0_r < kedg_pkg::V_NEG_ONE) begin
      region_nxt = kedg_pkg::REG_BELOW;
    end else if (v0_r <= kedg_pkg::V_ZERO) begin
      region_nxt = kedg_pkg::REG_LIN;
    end else if (v0_r <= kedg_pkg::V_ONE) begin
      region_nxt = kedg_pkg::REG_EXP;
    end else if (v0_r <= kedg_pkg::V_T24) begin
      region_nxt = kedg_pkg::REG_CIRC;
    end else begin
      region_nxt = kedg_pkg::REG_RCP;
    end
  end

  // linear piece: 0.5 + 0.62*(-v), rounded
  logic [16:0] lin_mag;
  logic [33:0] lin_prod;
  logic [16:0] lin_gain;

  assign lin_mag  = 17'(-v0_r);
  assign lin_prod = 34'(lin_mag) * 34'(kedg_pkg::K062) + 34'(kedg_pkg::GAIN_HALF);
  assign lin_gain = kedg_pkg::GAIN_HALF + 17'(lin_prod >> kedg_pkg::FRAC_BITS);

  // ------------------------------------------------------ reciprocal lane
  // 0.225/v as restoring long division, one quotient bit per stage
  localparam int RS = kedg_pkg::RCP_STEPS;

  logic [30:0] rc_num;
  logic [24:0] rc_rem [0:RS];
  logic [22:0] rc_den [0:RS];
  logic [RS-1:0] rc_low [0:RS];
  logic [RS-1:0] rc_quo [0:RS];
  logic [24:0] rc_rem0_r;
  logic [22:0] rc_den0_r;
  logic [RS-1:0] rc_low0_r;

  assign rc_num = kedg_pkg::K0225 + 31'(v0_r[22:1]);

  always_ff @(posedge clk) begin
    rc_rem0_r <= 25'(rc_num >> RS);
    rc_den0_r <= v0_r[22:0];
    rc_low0_r <= rc_num[RS-1:0];
  end

  assign rc_rem[0] = rc_rem0_r;
  assign rc_den[0] = rc_den0_r;
  assign rc_low[0] = rc_low0_r;
  assign rc_quo[0] = '0;

  for (genvar i = 0; i < RS; i++) begin : g_rcp
    logic [25:0]   rem_sh;
    logic [24:0]   rem_r;
    logic [22:0]   den_r;
    logic [RS-1:0] low_r;
    logic [RS-1:0] quo_r;
    logic          ge;

    assign rem_sh = {rc_rem[i], rc_low[i][RS-1]};
    assign ge     = rem_sh >= 26'(rc_den[i]);

    always_ff @(posedge clk) begin
      rem_r <= ge ? 25'(rem_sh - 26'(rc_den[i])) : 25'(rem_sh);
      den_r <= rc_den[i];
      low_r <= {rc_low[i][RS-2:0], 1'b0};
      quo_r <= {rc_quo[i][RS-2:0], ge};
    end

    assign rc_rem[i+1] = rem_r;
    assign rc_den[i+1] = den_r;
    assign rc_low[i+1] = low_r;
    assign rc_quo[i+1] = quo_r;
  end

  // -------------------------------------------------------- circular lane
  // u = 0.38 - 0.1v, d = 0.1184 - u^2, s = sqrt(d), gain = 0.4 - s
  localparam int SQ = kedg_pkg::SQ_STEPS;

  logic [44:0] cw_prod;
  logic [29:0] cw_r;
  logic [28:0] cu_r;
  logic [57:0] cu_sq;
  logic [27:0] cu2_r;
  logic [26:0] cd_r;

  assign cw_prod = 45'(v0_r[17:0]) * 45'(kedg_pkg::K01);
  assign cu_sq   = 58'(cu_r) * 58'(cu_r);

  always_ff @(posedge clk) begin
    cw_r  <= 30'(cw_prod >> kedg_pkg::FRAC_BITS);
    cu_r  <= 29'(30'(kedg_pkg::K038) - cw_r);
    cu2_r <= 28'(cu_sq >> 30);
    cd_r  <= (28'(kedg_pkg::K01184) > cu2_r) ? 27'(28'(kedg_pkg::K01184) - cu2_r) : '0;
  end

  logic [31:0] sq_rem [0:SQ];
  logic [28:0] sq_res [0:SQ];
  logic [57:0] sq_rad [0:SQ];

  assign sq_rem[0] = '0;
  assign sq_res[0] = '0;
  assign sq_rad[0] = {1'b0, cd_r, 30'b0};

  // digit-by-digit square root, one result bit per stage
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;
    logic [31:0] rem_r;
    logic [28:0] res_r;
    logic [57:0] rad_r;

    assign rem_sh = {sq_rem[i], sq_rad[i][57:56]};
    assign trial  = {3'b0, sq_res[i], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      rem_r <= ge ? 32'(rem_sh - trial) : 32'(rem_sh);
      res_r <= {sq_res[i][27:0], ge};
      rad_r <= {sq_rad[i][55:0], 2'b00};
    end

    assign sq_rem[i+1] = rem_r;
    assign sq_res[i+1] = res_r;
    assign sq_rad[i+1] = rad_r;
  end

  logic [28:0] circ_g;
  logic [16:0] circ_gain;

  assign circ_g    = (kedg_pkg::K04 > sq_res[SQ]) ? kedg_pkg::K04 - sq_res[SQ] : '0;
  assign circ_gain = 17'((30'(circ_g) + (30'd1 << (29 - kedg_pkg::FRAC_BITS)))
                         >> (30 - kedg_pkg::FRAC_BITS));

  // ----------------------------------------------------- exponential lane
  // 0.5*exp(-0.95v) as a 17-term Taylor sum, three stages per term
  localparam int NT = kedg_pkg::EXP_TERMS;

  logic [46:0]        ex_prod0;
  logic [29:0]        ex_t0_r;
  logic [29:0]        ex_t    [0:NT];
  logic [30:0]        ex_term [0:NT];
  logic signed [32:0] ex_sum  [0:NT];

  assign ex_prod0 = 47'(v0_r[16:0]) * 47'(kedg_pkg::K095);

  always_ff @(posedge clk) begin
    ex_t0_r <= 30'(ex_prod0 >> kedg_pkg::FRAC_BITS);
  end

  assign ex_t[0]    = ex_t0_r;
  assign ex_term[0] = 31'(kedg_pkg::Q30_ONE);
  assign ex_sum[0]  = 33'(kedg_pkg::Q30_ONE);

  for (genvar n = 1; n <= NT; n++) begin : g_exp
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / n);
    localparam logic [4:0]  DIV   = 5'(n);

    logic [60:0]        a_prod;
    logic [30:0]        a_p_r;
    logic [29:0]        a_t_r;
    logic signed [32:0] a_sum_r;
    logic [63:0]        b_prod;
    logic [30:0]        b_q0_r;
    logic [30:0]        b_p_r;
    logic [29:0]        b_t_r;
    logic signed [32:0] b_sum_r;
    logic [35:0]        c_rem;
    logic [30:0]        c_q;
    logic [30:0]        c_term_r;
    logic [29:0]        c_t_r;
    logic signed [32:0] c_sum_r;

    // term * t in Q30
    assign a_prod = 61'(ex_term[n-1]) * 61'(ex_t[n-1]);

    always_ff @(posedge clk) begin
      a_p_r   <= 31'(a_prod >> 30);
      a_t_r   <= ex_t[n-1];
      a_sum_r <= ex_sum[n-1];
    end

    // divide by n: reciprocal estimate, low by at most one
    assign b_prod = 64'(a_p_r) * 64'(RECIP);

    always_ff @(posedge clk) begin
      b_q0_r  <= 31'(b_prod >> 32);
      b_p_r   <= a_p_r;
      b_t_r   <= a_t_r;
      b_sum_r <= a_sum_r;
    end

    assign c_rem = 36'(b_p_r) - 36'(b_q0_r) * 36'(DIV);
    assign c_q   = b_q0_r + 31'(c_rem >= 36'(DIV));

    always_ff @(posedge clk) begin
      c_term_r <= c_q;
      c_t_r    <= b_t_r;
      c_sum_r  <= ((n % 2) == 1) ? b_sum_r - $signed({2'b00, c_q})
                                 : b_sum_r + $signed({2'b00, c_q});
    end

    assign ex_t[n]    = c_t_r;
    assign ex_term[n] = c_term_r;
    assign ex_sum[n]  = c_sum_r;
  end

  logic [31:0] ex_pos;
  logic [16:0] exp_gain;

  assign ex_pos   = ex_sum[NT][32] ? '0 : ex_sum[NT][31:0];
  assign exp_gain = 17'((33'(ex_pos) + (33'd1 << (30 - kedg_pkg::FRAC_BITS)))
                        >> (31 - kedg_pkg::FRAC_BITS));

  // ------------------------------------------------------ common gain pipe
  always_comb begin
    for (int k = 1; k <= LAST; k++) gain_nxt[k] = '0;
    for (int k = 2; k <= LAST; k++) gain_nxt[k] = gain_r[k-1];
    if (region_nxt == kedg_pkg::REG_BELOW) begin
      gain_nxt[1] = kedg_pkg::GAIN_ONE;
    end else if (region_nxt == kedg_pkg::REG_LIN) begin
      gain_nxt[1] = lin_gain;
    end
    if (region_r[kedg_pkg::RCP_INS-1] == kedg_pkg::REG_RCP) begin
      gain_nxt[kedg_pkg::RCP_INS] = 17'(rc_quo[RS]);
    end
    if (region_r[kedg_pkg::CIRC_INS-1] == kedg_pkg::REG_CIRC) begin
      gain_nxt[kedg_pkg::CIRC_INS] = circ_gain;
    end
    if (region_r[kedg_pkg::EXP_INS-1] == kedg_pkg::REG_EXP) begin
      gain_nxt[kedg_pkg::EXP_INS] = exp_gain;
    end
  end

  always_ff @(posedge clk) begin
    region_r[1] <= region_nxt;
    for (int k = 2; k <= LAST; k++) region_r[k] <= region_r[k-1];
    for (int k = 1; k <= LAST; k++) gain_r[k] <= gain_nxt[k];
  end

  assign out_valid      = vld_r[LAST];
  assign out_field_gain = gain_r[LAST];
  assign out_region     = region_r[LAST];

endmodule

// ===== rtl/kedg_chk.sv =====
module kedg_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [23:0] in_diffraction_param,
  input logic               out_valid,
  input logic [16:0]        out_field_gain,
  input logic [2:0]         out_region
);

  localparam int LAT = kedg_pkg::LATENCY;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_below_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == kedg_pkg::REG_BELOW) |->
      out_field_gain == kedg_pkg::GAIN_ONE)
    else $error("gain below minus one is not unity");

  a_below_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_diffraction_param, LAT) < kedg_pkg::V_NEG_ONE) |->
      out_region == kedg_pkg::REG_BELOW)
    else $error("region does not follow input");

  a_rcp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == kedg_pkg::REG_RCP) |-> out_field_gain < 17'd8192)
    else $error("reciprocal gain out of range");

endmodule

bind knife_edge_diffraction_gain kedg_chk u_kedg_chk (.*);

// ===== tb/sv/kedg_checker.sv =====
`timescale 1ns / 1ps

module kedg_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic signed [23:0] in_diffraction_param,
  input  logic              out_valid,
  input  logic [16:0]       out_field_gain,
  input  logic [2:0]        out_region,
  output int                fail_count,
  output int                pending_gains,
  output int                gains_seen
);

  typedef struct packed {
    logic [16:0]       gain;
    kedg_pkg::region_t region;
  } gain_beat_t;

  gain_beat_t expected_gains[$];

  int fails   = 0;
  int seen    = 0;
  int pending = 0;

  assign fail_count    = fails;
  assign gains_seen    = seen;
  assign pending_gains = pending;

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic gain_beat_t knife_gain(logic signed [23:0] vraw);
    longint v;
    longint unsigned x, g, t, term, au, u2, d, s;
    longint sum, u;
    gain_beat_t r;
    v = vraw;
    if (v < -longint'(kedg_pkg::ONE_U)) begin
      g = kedg_pkg::ONE_U;
      r.region = kedg_pkg::REG_BELOW;
    end else if (v <= 0) begin
      x = -v;
      g = kedg_pkg::ONE_U / 2 +
          ((kedg_pkg::K062_U * x + kedg_pkg::ONE_U / 2) >> kedg_pkg::FRAC_BITS);
      r.region = kedg_pkg::REG_LIN;
    end else if (v <= longint'(kedg_pkg::ONE_U)) begin
      x = v;
      t = (x * kedg_pkg::K095_U) >> kedg_pkg::FRAC_BITS;
      term = kedg_pkg::Q30_ONE;
      sum = kedg_pkg::Q30_ONE;
      for (int n = 1; n <= kedg_pkg::EXP_TERMS; n++) begin
        term = ((term * t) >> 30) / n;
        if (n & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      g = (longint'(sum) + (64'd1 << (30 - kedg_pkg::FRAC_BITS)))
          >> (31 - kedg_pkg::FRAC_BITS);
      r.region = kedg_pkg::REG_EXP;
    end else if (v <= longint'(kedg_pkg::T24_U)) begin
      x = v;
      u = longint'(kedg_pkg::K038_U) -
          longint'((x * kedg_pkg::K01_U) >> kedg_pkg::FRAC_BITS);
      au = (u < 0) ? -u : u;
      u2 = (au * au) >> 30;
      d = (kedg_pkg::K01184_U > u2) ? kedg_pkg::K01184_U - u2 : 0;
      s = int_sqrt(d << 30);
      g = (kedg_pkg::K04_U > s) ? kedg_pkg::K04_U - s : 0;
      g = (g + (64'd1 << (29 - kedg_pkg::FRAC_BITS))) >> (30 - kedg_pkg::FRAC_BITS);
      r.region = kedg_pkg::REG_CIRC;
    end else begin
      x = v;
      g = (kedg_pkg::K0225_U + x / 2) / x;
      r.region = kedg_pkg::REG_RCP;
    end
    r.gain = (g > 131071) ? 17'd131071 : g[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fails++;
  endtask

  // sample at the edge; beats were driven by NBAs so values are stable
  always @(posedge clk) begin
    gain_beat_t want;
    if (rst_n && start && !busy) expected_gains.push_back(knife_gain(in_diffraction_param));
    if (rst_n && out_valid) begin
      seen++;
      if (expected_gains.size() == 0) begin
        report_mismatch("unexpected result beat");
      end else begin
        want = expected_gains.pop_front();
        if (out_field_gain !== want.gain)
          report_mismatch($sformatf("gain %0d want %0d", out_field_gain, want.gain));
        if (out_region !== want.region)
          report_mismatch($sformatf("region %0d want %0d", out_region, want.region));
      end
    end
    pending = expected_gains.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic signed [23:0] in_diffraction_param = '0;
  logic              out_valid;
  logic [16:0]       out_field_gain;
  logic [2:0]        out_region;
  int                fail_count, pending_gains, gains_seen;
  int                sent_beats;

  always #5 clk = ~clk;

  knife_edge_diffraction_gain dut (.*);

  kedg_checker u_chk (.*);

  // Directed values: edges of each piece, field extremes, bit patterns.
  logic signed [23:0] edge_params[$] = '{
    24'sh800000, 24'sh7FFFFF, -24'sd65537, -24'sd65536, -24'sd65535,
    -24'sd1, 24'sd0, 24'sd1, 24'sd32768, 24'sd65535, 24'sd65536,
    24'sd65537, 24'sd100000, 24'sd157286, 24'sd157287, 24'sd157288,
    24'sd200000, 24'sh555555, 24'shAAAAAA, -24'sd32768, 24'sd131072,
    24'sd2, 24'sh400000
  };

  // One beat: wait out an optional gap, then hold start until accepted.
  task automatic send_beat(logic signed [23:0] v, bit allow_gap);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    in_diffraction_param <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_beats++;
  endtask

  // Mostly the interesting window around -1..2.4, with some full-range values.
  function automatic logic signed [23:0] random_param();
    case ($urandom_range(0, 5))
      0: return $signed(24'($urandom));
      1: return -$signed(24'($urandom_range(0, 65536)));
      2: return $signed(24'($urandom_range(1, 65536)));
      3: return $signed(24'($urandom_range(65537, 157286)));
      4: return $signed(24'($urandom_range(157287, 2000000)));
      default: return $signed(24'($urandom_range(0, 400000))) - 24'sd150000;
    endcase
  endfunction

  initial begin
    sent_beats = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (edge_params[i]) send_beat(edge_params[i], 1'b0);
    for (int i = 0; i < 500; i++) send_beat(random_param(), 1'b1);
    // drain the pipe completely before resuming
    start <= 1'b0;
    @(posedge clk);
    while (pending_gains != 0) @(posedge clk);
    for (int i = 0; i < 300; i++) send_beat(random_param(), 1'b1);
    // closing stretch: back to back, no gaps
    for (int i = 0; i < 150; i++) send_beat(random_param(), 1'b0);
    start <= 1'b0;
    @(posedge clk);
    while (pending_gains != 0) @(posedge clk);
    repeat (kedg_pkg::LATENCY + 10) @(posedge clk);
    $display("Sent %0d parameters across all five gain pieces and field extremes;",
             sent_beats);
    $display("checked %0d result beats, including back-to-back and drained phases.",
             gains_seen);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
